// ===== hdl/rtwmm_pkg.sv =====
`timescale 1ns / 1ps

package rtwmm_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 16;
    localparam int TIER_W   = 3;
    localparam int HELD_W   = 4;
    localparam int SECS_W   = 32;
    localparam int CFG_IDX_W = 2;

    // Event kinds
    localparam logic CMD_APPROVE = 1'b0;
    localparam logic CMD_DENY    = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_TIER_FOUR  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER_THREE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER_TWO   = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIER_ONE   = 2'd3;

    localparam logic [SAMPLE_W-1:0] RST_TIER_FOUR  = 16'd15;
    localparam logic [SAMPLE_W-1:0] RST_TIER_THREE = 16'd30;
    localparam logic [SAMPLE_W-1:0] RST_TIER_TWO   = 16'd60;
    localparam logic [SAMPLE_W-1:0] RST_TIER_ONE   = 16'd120;

    localparam logic [SAMPLE_W-1:0] SAT_SECONDS  = 16'hFFFF;
    localparam logic [TIER_W-1:0]   NEUTRAL_TIER = 3'd2;
    localparam logic [TIER_W-1:0]   MAX_TIER     = 3'd4;
    localparam logic [COUNT_W:0]    PENALTY_MIN_EVENTS = 17'd3;

    typedef struct packed {
        logic              command;
        logic [SECS_W-1:0] response_seconds;
    } t_req;

    typedef struct packed {
        logic [SAMPLE_W-1:0] median_seconds;
        logic [TIER_W-1:0]   mood_tier;
        logic [COUNT_W-1:0]  approval_count;
        logic [COUNT_W-1:0]  denial_count;
        logic [HELD_W-1:0]   samples_held;
    } t_rsp;

    typedef struct packed {
        logic [SAMPLE_W-1:0] four;
        logic [SAMPLE_W-1:0] three;
        logic [SAMPLE_W-1:0] two;
        logic [SAMPLE_W-1:0] one;
    } t_thresh;

    // Sequencer strobes to the cell row
    typedef struct packed {
        logic load;
        logic count;
    } t_cell_ctl;

endpackage

// ===== hdl/rtwmm_cell.sv =====
`timescale 1ns / 1ps

// One window slot: holds a sample and ranks it against the values
// rotating past it.
module rtwmm_cell #(
    parameter int CNT_W = 4
) (
    input  logic                               i_clk,
    input  rtwmm_pkg::t_cell_ctl               i_ctl,
    input  logic                               i_wr,
    input  logic [rtwmm_pkg::SAMPLE_W-1:0]     i_wr_data,
    input  logic                               i_sv,
    input  logic                               i_pv_load,
    input  logic [rtwmm_pkg::SAMPLE_W-1:0]     i_pass,
    input  logic                               i_pass_v,
    output logic [rtwmm_pkg::SAMPLE_W-1:0]     o_sample,
    output logic [rtwmm_pkg::SAMPLE_W-1:0]     o_pass,
    output logic                               o_pass_v,
    output logic [CNT_W-1:0]                   o_lt,
    output logic [CNT_W-1:0]                   o_le
);

    logic [rtwmm_pkg::SAMPLE_W-1:0] r_sample;
    logic [rtwmm_pkg::SAMPLE_W-1:0] r_pass;
    logic                           r_pass_v;
    logic [CNT_W-1:0]               r_lt;
    logic [CNT_W-1:0]               r_le;
    logic                           w_hit;

    assign w_hit = i_sv && r_pass_v;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            if (i_wr) begin
                r_sample <= i_wr_data;
                r_pass   <= i_wr_data;
            end else begin
                r_pass   <= r_sample;
            end
            r_pass_v <= i_pv_load;
            r_lt     <= '0;
            r_le     <= '0;
        end else if (i_ctl.count) begin
            if (w_hit && (r_pass < r_sample)) begin
                r_lt <= r_lt + CNT_W'(1);
            end
            if (w_hit && (r_pass <= r_sample)) begin
                r_le <= r_le + CNT_W'(1);
            end
            r_pass   <= i_pass;
            r_pass_v <= i_pass_v;
        end
    end

    assign o_sample = r_sample;
    assign o_pass   = r_pass;
    assign o_pass_v = r_pass_v;
    assign o_lt     = r_lt;
    assign o_le     = r_le;

endmodule

// ===== hdl/rtwmm_tier.sv =====
`timescale 1ns / 1ps

// Median to mood tier, then the denial penalty with a floor at zero.
module rtwmm_tier (
    input  logic [rtwmm_pkg::SAMPLE_W-1:0] i_median,
    input  rtwmm_pkg::t_thresh             i_thresh,
    input  logic [rtwmm_pkg::COUNT_W-1:0]  i_approvals,
    input  logic [rtwmm_pkg::COUNT_W-1:0]  i_denials,
    output logic [rtwmm_pkg::TIER_W-1:0]   o_tier
);

    logic [rtwmm_pkg::TIER_W-1:0]  w_base;
    logic [rtwmm_pkg::TIER_W-1:0]  w_pen;
    logic [rtwmm_pkg::COUNT_W:0]   w_total;
    logic [rtwmm_pkg::COUNT_W:0]   w_den2;

    assign w_total = {1'b0, i_approvals} + {1'b0, i_denials};
    assign w_den2  = {i_denials, 1'b0};

    always_comb begin
        if (i_median == '0) begin
            w_base = rtwmm_pkg::NEUTRAL_TIER;
        end else if (i_median < i_thresh.four) begin
            w_base = 3'd4;
        end else if (i_median < i_thresh.three) begin
            w_base = 3'd3;
        end else if (i_median < i_thresh.two) begin
            w_base = 3'd2;
        end else if (i_median < i_thresh.one) begin
            w_base = 3'd1;
        end else begin
            w_base = 3'd0;
        end

        w_pen = 3'd0;
        if (w_total >= rtwmm_pkg::PENALTY_MIN_EVENTS) begin
            if (i_denials > i_approvals) begin
                w_pen = 3'd2;
            end else if (w_den2 > {1'b0, i_approvals}) begin
                w_pen = 3'd1;
            end
        end

        o_tier = (w_base > w_pen) ? (w_base - w_pen) : 3'd0;
    end

endmodule

// ===== hdl/response_time_window_median_mood_top.sv =====
`timescale 1ns / 1ps

// Response-time window median and mood tier.
//
// Request channel (i_req_valid / o_req_stall / i_req): one event per request,
// an approval carrying a response time (saturated to 16 bits) or a denial.
// Response channel (o_rsp_valid / i_rsp_stall / o_rsp): exactly one result
// per request: window median, mood tier, both counts and samples held.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data): the four tier thresholds;
// the user must write them only while the block is idle (not enforced).
//
// An accepted request runs through the update, count, pick and tier states,
// and its result is then registered for o_rsp_valid. One request is in flight
// at a time: a new request is taken only after the last one loaded its result.
// In the rank sweep every sample rotates once past every cell of the row.
// Reset (synchronous, active low) empties the window, clears the counts and
// loads the default thresholds. A stalled response holds in the output
// register; the block still takes the next request and runs it, and waits
// with its own result until the register frees up.
module response_time_window_median_mood_top #(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_req_valid,
    output logic                                o_req_stall,
    input  rtwmm_pkg::t_req                     i_req,
    output logic                                o_rsp_valid,
    input  logic                                i_rsp_stall,
    output rtwmm_pkg::t_rsp                     o_rsp,
    input  logic                                i_cfg_we,
    input  logic [rtwmm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [rtwmm_pkg::SAMPLE_W-1:0]      i_cfg_data
);

    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int PTR_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_UPDATE = 3'd1;
    localparam logic [2:0] S_COUNT  = 3'd2;
    localparam logic [2:0] S_PICK   = 3'd3;
    localparam logic [2:0] S_TIER   = 3'd4;

    logic [2:0]                        r_state;
    logic [CNT_W-1:0]                  r_step;
    rtwmm_pkg::t_req                   r_evt;
    rtwmm_pkg::t_thresh                r_thresh;
    logic [PTR_W-1:0]                  r_wr_ptr;
    logic [CNT_W-1:0]                  r_valid_cnt;
    logic [CNT_W-1:0]                  n_valid_cnt;
    logic [rtwmm_pkg::COUNT_W-1:0]     r_approvals;
    logic [rtwmm_pkg::COUNT_W-1:0]     r_denials;
    logic [rtwmm_pkg::SAMPLE_W-1:0]    r_median;
    logic [rtwmm_pkg::SAMPLE_W-1:0]    n_median;
    logic                              r_rsp_valid;
    rtwmm_pkg::t_rsp                   r_rsp;

    logic                              w_req_take;
    logic                              w_approve;
    logic                              w_rsp_load;
    logic [rtwmm_pkg::SAMPLE_W-1:0]    w_sat;
    logic [rtwmm_pkg::TIER_W-1:0]      w_tier;
    logic [CNT_W-1:0]                  w_half;
    rtwmm_pkg::t_cell_ctl              w_ctl;

    logic [WINDOW_DEPTH-1:0]           w_wr;
    logic [WINDOW_DEPTH-1:0]           w_sv;
    logic [WINDOW_DEPTH-1:0]           w_pv_load;
    logic [WINDOW_DEPTH-1:0]           w_pass_v;
    logic [rtwmm_pkg::SAMPLE_W-1:0]    w_sample [WINDOW_DEPTH];
    logic [rtwmm_pkg::SAMPLE_W-1:0]    w_pass   [WINDOW_DEPTH];
    logic [CNT_W-1:0]                  w_lt     [WINDOW_DEPTH];
    logic [CNT_W-1:0]                  w_le     [WINDOW_DEPTH];

    assign o_req_stall = (r_state != S_IDLE);
    assign w_req_take  = i_req_valid && !o_req_stall;
    assign w_approve   = (r_state == S_UPDATE) && (r_evt.command == rtwmm_pkg::CMD_APPROVE);
    assign w_rsp_load  = (r_state == S_TIER) && (!r_rsp_valid || !i_rsp_stall);

    // Saturate the response time to 16 bits
    assign w_sat = (|r_evt.response_seconds[rtwmm_pkg::SECS_W-1:rtwmm_pkg::SAMPLE_W])
                 ? rtwmm_pkg::SAT_SECONDS
                 : r_evt.response_seconds[rtwmm_pkg::SAMPLE_W-1:0];

    assign n_valid_cnt = (w_approve && (r_valid_cnt < CNT_W'(WINDOW_DEPTH)))
                       ? r_valid_cnt + CNT_W'(1) : r_valid_cnt;

    assign w_ctl.load  = (r_state == S_UPDATE);
    assign w_ctl.count = (r_state == S_COUNT);
    assign w_half      = r_valid_cnt >> 1;

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_req_take) begin
                        r_state <= S_UPDATE;
                    end
                end
                S_UPDATE: begin
                    r_step  <= '0;
                    r_state <= S_COUNT;
                end
                S_COUNT: begin
                    r_step <= r_step + CNT_W'(1);
                    if (r_step == CNT_W'(WINDOW_DEPTH - 1)) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    r_state <= S_TIER;
                end
                S_TIER: begin
                    if (w_rsp_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_req_take) begin
            r_evt <= i_req;
        end
    end

    // Thresholds
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.four  <= rtwmm_pkg::RST_TIER_FOUR;
            r_thresh.three <= rtwmm_pkg::RST_TIER_THREE;
            r_thresh.two   <= rtwmm_pkg::RST_TIER_TWO;
            r_thresh.one   <= rtwmm_pkg::RST_TIER_ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                rtwmm_pkg::CFG_TIER_FOUR:  r_thresh.four  <= i_cfg_data;
                rtwmm_pkg::CFG_TIER_THREE: r_thresh.three <= i_cfg_data;
                rtwmm_pkg::CFG_TIER_TWO:   r_thresh.two   <= i_cfg_data;
                rtwmm_pkg::CFG_TIER_ONE:   r_thresh.one   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Window bookkeeping and event counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr    <= '0;
            r_valid_cnt <= '0;
            r_approvals <= '0;
            r_denials   <= '0;
        end else if (r_state == S_UPDATE) begin
            r_valid_cnt <= n_valid_cnt;
            if (w_approve) begin
                r_approvals <= r_approvals + 16'd1;
                r_wr_ptr    <= (r_wr_ptr == PTR_W'(WINDOW_DEPTH - 1))
                             ? '0 : r_wr_ptr + PTR_W'(1);
            end else begin
                r_denials <= r_denials + 16'd1;
            end
        end
    end

    // Row of rank cells; passing values rotate one cell per cycle in the count state
    for (genvar g = 0; g < WINDOW_DEPTH; g++) begin : g_cell
        localparam int PREV = (g == 0) ? WINDOW_DEPTH - 1 : g - 1;

        assign w_wr[g]      = w_approve && (r_wr_ptr == PTR_W'(g));
        assign w_sv[g]      = (CNT_W'(g) < r_valid_cnt);
        assign w_pv_load[g] = (CNT_W'(g) < n_valid_cnt);

        rtwmm_cell #(
            .CNT_W(CNT_W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_wr      (w_wr[g]),
            .i_wr_data (w_sat),
            .i_sv      (w_sv[g]),
            .i_pv_load (w_pv_load[g]),
            .i_pass    (w_pass[PREV]),
            .i_pass_v  (w_pass_v[PREV]),
            .o_sample  (w_sample[g]),
            .o_pass    (w_pass[g]),
            .o_pass_v  (w_pass_v[g]),
            .o_lt      (w_lt[g]),
            .o_le      (w_le[g])
        );
    end

    // Median: a valid cell with lt <= n/2 < le. Ties hold equal values,
    // so OR-ing the hits is safe. Empty window gives zero.
    always_comb begin
        n_median = '0;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (w_sv[i] && (w_lt[i] <= w_half) && (w_le[i] > w_half)) begin
                n_median = n_median | w_sample[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_PICK) begin
            r_median <= n_median;
        end
    end

    rtwmm_tier u_tier (
        .i_median    (r_median),
        .i_thresh    (r_thresh),
        .i_approvals (r_approvals),
        .i_denials   (r_denials),
        .o_tier      (w_tier)
    );

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_rsp_load) begin
            r_rsp_valid <= 1'b1;
        end else if (!i_rsp_stall) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rsp_load) begin
            r_rsp.median_seconds <= r_median;
            r_rsp.mood_tier      <= w_tier;
            r_rsp.approval_count <= r_approvals;
            r_rsp.denial_count   <= r_denials;
            r_rsp.samples_held   <= rtwmm_pkg::HELD_W'(r_valid_cnt);
        end
    end

    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    // Checks
    a_rsp_after_tier: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> $past(r_state) == S_TIER)
        else $error("response raised outside tier step");

    a_take_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_req_take |=> r_state == S_UPDATE)
        else $error("accepted request did not start update");

    a_held_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid_cnt <= CNT_W'(WINDOW_DEPTH))
        else $error("valid sample count beyond window");

    a_tier_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp_load |=> o_rsp.mood_tier <= rtwmm_pkg::MAX_TIER)
        else $error("mood tier out of range");

endmodule

// ===== tb/tb_response_time_window_median_mood_top.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the response-time median / mood block.
// A local model of the window, counts and thresholds predicts one report per
// accepted request; a monitor pops and compares each report as it leaves.
module tb_response_time_window_median_mood_top;

    localparam int WIN = 8;
    localparam int LATENCY = WIN + 3;   // request accept to report valid
    localparam int STUCK_LIMIT = 4000;  // cycles with no handshake at all

    // ------------------------------------------------------------------
    // DUT signals, every input driven to known values from time zero
    // ------------------------------------------------------------------
    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_req_valid = 1'b0;
    logic                            o_req_stall;
    rtwmm_pkg::t_req                 i_req = '0;
    logic                            o_rsp_valid;
    logic                            i_rsp_stall = 1'b0;
    rtwmm_pkg::t_rsp                 o_rsp;
    logic                            i_cfg_we = 1'b0;
    logic [rtwmm_pkg::CFG_IDX_W-1:0] i_cfg_idx = rtwmm_pkg::CFG_TIER_FOUR;
    logic [rtwmm_pkg::SAMPLE_W-1:0]  i_cfg_data = '0;

    response_time_window_median_mood_top #(
        .WINDOW_DEPTH(WIN)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_stall (o_req_stall),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .o_rsp       (o_rsp),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow state of the block
    // ------------------------------------------------------------------
    logic [rtwmm_pkg::SAMPLE_W-1:0] window_samples [WIN];
    int                             window_slot;
    int                             window_fill;
    logic [rtwmm_pkg::COUNT_W-1:0]  approvals;
    logic [rtwmm_pkg::COUNT_W-1:0]  denials;
    rtwmm_pkg::t_thresh             tier_limits;

    rtwmm_pkg::t_rsp awaited_reports [$];
    rtwmm_pkg::t_rsp want;
    int   error_count = 0;
    int   stuck_cycles = 0;

    // Idle percentages for the request sender and the report sink
    int sender_gap_pct = 26;
    int sink_stall_pct = 86;

    // Apply one event to the shadow state and return the report it yields.
    function automatic rtwmm_pkg::t_rsp advance_window(rtwmm_pkg::t_req ev);
        rtwmm_pkg::t_rsp                rep;
        logic [rtwmm_pkg::SAMPLE_W-1:0] med;
        int                             i, j, less, not_more, mid, tier, a, d;
        if (ev.command == rtwmm_pkg::CMD_APPROVE) begin
            approvals = approvals + 1'b1;
            window_samples[window_slot] = (ev.response_seconds > rtwmm_pkg::SAT_SECONDS) ?
                rtwmm_pkg::SAT_SECONDS : ev.response_seconds[rtwmm_pkg::SAMPLE_W-1:0];
            window_slot = (window_slot + 1) % WIN;
            if (window_fill < WIN) window_fill++;
        end else begin
            denials = denials + 1'b1;
        end

        // Upper median by rank: the sample whose rank range covers fill/2.
        med = '0;
        mid = window_fill / 2;
        for (i = 0; i < window_fill; i++) begin
            less = 0;
            not_more = 0;
            for (j = 0; j < window_fill; j++) begin
                if (window_samples[j] < window_samples[i]) less++;
                if (window_samples[j] <= window_samples[i]) not_more++;
            end
            if (less <= mid && mid < not_more) med = window_samples[i];
        end

        // Thresholds go in fixed order; first hit wins even if unordered.
        if (med == '0) tier = int'(rtwmm_pkg::NEUTRAL_TIER);
        else if (med < tier_limits.four) tier = 4;
        else if (med < tier_limits.three) tier = 3;
        else if (med < tier_limits.two) tier = 2;
        else if (med < tier_limits.one) tier = 1;
        else tier = 0;

        // Denial penalty on the wrapped counts, once enough events were seen.
        a = int'(approvals);
        d = int'(denials);
        if (a + d >= int'(rtwmm_pkg::PENALTY_MIN_EVENTS)) begin
            if (d > a) tier -= 2;
            else if (2 * d > a) tier -= 1;
        end
        if (tier < 0) tier = 0;

        rep.median_seconds = med;
        rep.mood_tier      = tier[rtwmm_pkg::TIER_W-1:0];
        rep.approval_count = approvals;
        rep.denial_count   = denials;
        rep.samples_held   = window_fill[rtwmm_pkg::HELD_W-1:0];
        return rep;
    endfunction

    function automatic rtwmm_pkg::t_req make_event(logic cmd,
                                                   logic [rtwmm_pkg::SECS_W-1:0] secs);
        rtwmm_pkg::t_req ev;
        ev.command = cmd;
        ev.response_seconds = secs;
        return ev;
    endfunction

    // Random event: mostly times around the tier boundaries, some at the
    // saturation point, some full 32-bit noise.
    function automatic rtwmm_pkg::t_req random_event(int deny_pct);
        rtwmm_pkg::t_req ev;
        int              pick, base;
        ev.command = ($urandom_range(99) < deny_pct) ? rtwmm_pkg::CMD_DENY
                                                     : rtwmm_pkg::CMD_APPROVE;
        pick = $urandom_range(99);
        if (pick < 10) begin
            ev.response_seconds = '0;
        end else if (pick < 45) begin
            ev.response_seconds = $urandom_range(150);
        end else if (pick < 65) begin
            case ($urandom_range(3))
                0: base = int'(tier_limits.four);
                1: base = int'(tier_limits.three);
                2: base = int'(tier_limits.two);
                default: base = int'(tier_limits.one);
            endcase
            base = base + $urandom_range(2) - 1;
            if (base < 0) base = 0;
            ev.response_seconds = base;
        end else if (pick < 80) begin
            ev.response_seconds = $urandom_range(65545, 65525);
        end else begin
            ev.response_seconds = $urandom();
        end
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: random gap, then hold the request until taken.
    // Entered and left at a falling edge.
    // ------------------------------------------------------------------
    task automatic send_event(rtwmm_pkg::t_req ev);
        while ($urandom_range(99) < sender_gap_pct) begin
            i_req_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_req_valid <= 1'b1;
        i_req       <= ev;
        do @(posedge i_clk); while (o_req_stall !== 1'b0);
        awaited_reports.push_back(advance_window(ev));
        @(negedge i_clk);
    endtask

    // Drop the request line, drain every report, then let the block settle.
    task automatic quiesce();
        i_req_valid <= 1'b0;
        while (awaited_reports.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [rtwmm_pkg::CFG_IDX_W-1:0] idx,
                             logic [rtwmm_pkg::SAMPLE_W-1:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        case (idx)
            rtwmm_pkg::CFG_TIER_FOUR:  tier_limits.four  = value;
            rtwmm_pkg::CFG_TIER_THREE: tier_limits.three = value;
            rtwmm_pkg::CFG_TIER_TWO:   tier_limits.two   = value;
            default:                   tier_limits.one   = value;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic set_limits(logic [rtwmm_pkg::SAMPLE_W-1:0] four,
                              logic [rtwmm_pkg::SAMPLE_W-1:0] three,
                              logic [rtwmm_pkg::SAMPLE_W-1:0] two,
                              logic [rtwmm_pkg::SAMPLE_W-1:0] one);
        write_reg(rtwmm_pkg::CFG_TIER_FOUR, four);
        write_reg(rtwmm_pkg::CFG_TIER_THREE, three);
        write_reg(rtwmm_pkg::CFG_TIER_TWO, two);
        write_reg(rtwmm_pkg::CFG_TIER_ONE, one);
    endtask

    // New threshold set for a random chunk: sorted small, sorted wide,
    // unordered, fully random, or one of the extremes.
    task automatic pick_random_limits();
        logic [rtwmm_pkg::SAMPLE_W-1:0] f, t3, t2, t1;
        case ($urandom_range(5))
            0, 1: begin
                f  = rtwmm_pkg::SAMPLE_W'($urandom_range(40));
                t3 = rtwmm_pkg::SAMPLE_W'(f + $urandom_range(60));
                t2 = rtwmm_pkg::SAMPLE_W'(t3 + $urandom_range(80));
                t1 = rtwmm_pkg::SAMPLE_W'(t2 + $urandom_range(100));
            end
            2: begin
                f  = rtwmm_pkg::SAMPLE_W'($urandom_range(16000));
                t3 = rtwmm_pkg::SAMPLE_W'(f + $urandom_range(16000));
                t2 = rtwmm_pkg::SAMPLE_W'(t3 + $urandom_range(16000));
                t1 = rtwmm_pkg::SAMPLE_W'(t2 + $urandom_range(16000));
            end
            3: begin
                f  = rtwmm_pkg::SAMPLE_W'($urandom_range(300));
                t3 = rtwmm_pkg::SAMPLE_W'($urandom_range(300));
                t2 = rtwmm_pkg::SAMPLE_W'($urandom_range(300));
                t1 = rtwmm_pkg::SAMPLE_W'($urandom_range(300));
            end
            4: begin
                f  = rtwmm_pkg::SAMPLE_W'($urandom());
                t3 = rtwmm_pkg::SAMPLE_W'($urandom());
                t2 = rtwmm_pkg::SAMPLE_W'($urandom());
                t1 = rtwmm_pkg::SAMPLE_W'($urandom());
            end
            default: begin
                f  = $urandom_range(1) ? '1 : '0;
                t3 = f;
                t2 = f;
                t1 = f;
            end
        endcase
        set_limits(f, t3, t2, t1);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Empty window, ignored time on denial, penalty below and at the event
    // minimum, saturation, ring wrap, default tier edges, zero median.
    task automatic test_directed_events();
        send_event(make_event(rtwmm_pkg::CMD_DENY, 32'hFFFF_FFFF));    // empty window
        send_event(make_event(rtwmm_pkg::CMD_DENY, 32'h0000_0000));    // d > a, too few
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd0));         // zero median, -2
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd20));        // 2d > a, -1
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'hFFFF_FFFF)); // saturates
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd65536));     // just over
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd65534));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd1));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd14));        // window one short of full
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd15));        // window now full, ring wraps
        send_event(make_event(rtwmm_pkg::CMD_DENY, 32'h5A5A_A5A5));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd29));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd30));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd59));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd60));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd119));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd120));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'h8000_0000));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'h0000_FFFF));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd5));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd5));
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd5));
    endtask

    // Threshold extremes, unordered thresholds and a single-register write.
    task automatic test_threshold_settings();
        quiesce();
        set_limits('0, '0, '0, '0);
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd0));
        repeat (10) send_event(random_event(20));

        quiesce();
        set_limits('1, '1, '1, '1);
        send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'd65534));
        repeat (4) send_event(make_event(rtwmm_pkg::CMD_APPROVE, 32'hFFFF_FFFF));
        repeat (8) send_event(random_event(20));

        quiesce();
        set_limits(16'd500, 16'd40, 16'd100, 16'd20);      // out of order
        repeat (12) send_event(random_event(20));

        quiesce();
        write_reg(rtwmm_pkg::CFG_TIER_TWO, 16'd7);          // one register alone
        repeat (12) send_event(random_event(20));

        quiesce();
        set_limits(rtwmm_pkg::RST_TIER_FOUR, rtwmm_pkg::RST_TIER_THREE,
                   rtwmm_pkg::RST_TIER_TWO, rtwmm_pkg::RST_TIER_ONE);
    endtask

    // Random chunks with fresh thresholds. The denial share rises by phase
    // so the cumulative counts pass through all three penalty regions; the
    // idle pattern swaps at the second phase and drops to zero at the third.
    task automatic test_random_traffic();
        int chunk, deny_pct;
        for (chunk = 0; chunk < 30; chunk++) begin
            quiesce();
            if (chunk == 10) begin
                sender_gap_pct = 86;
                sink_stall_pct = 26;
            end else if (chunk == 20) begin
                sender_gap_pct = 0;
                sink_stall_pct = 0;
            end
            deny_pct = (chunk < 10) ? 30 : (chunk < 20) ? 55 : 80;
            pick_random_limits();
            repeat (50) send_event(random_event(deny_pct));
        end
    endtask

    // ------------------------------------------------------------------
    // Report sink: random stall, driven at the falling edge
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        i_rsp_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // Report checker: each accepted report against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_rsp_valid === 1'b1 && i_rsp_stall == 1'b0) begin
            if (awaited_reports.size() == 0) begin
                $error("report with no request outstanding");
                error_count++;
            end else begin
                want = awaited_reports.pop_front();
                if (o_rsp.median_seconds !== want.median_seconds) begin
                    $error("median_seconds: expected %0d, got %0d",
                           want.median_seconds, o_rsp.median_seconds);
                    error_count++;
                end
                if (o_rsp.mood_tier !== want.mood_tier) begin
                    $error("mood_tier: expected %0d, got %0d",
                           want.mood_tier, o_rsp.mood_tier);
                    error_count++;
                end
                if (o_rsp.approval_count !== want.approval_count) begin
                    $error("approval_count: expected %0d, got %0d",
                           want.approval_count, o_rsp.approval_count);
                    error_count++;
                end
                if (o_rsp.denial_count !== want.denial_count) begin
                    $error("denial_count: expected %0d, got %0d",
                           want.denial_count, o_rsp.denial_count);
                    error_count++;
                end
                if (o_rsp.samples_held !== want.samples_held) begin
                    $error("samples_held: expected %0d, got %0d",
                           want.samples_held, o_rsp.samples_held);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: any handshake on either channel counts as progress.
    always @(posedge i_clk) begin
        if ((i_req_valid && o_req_stall === 1'b0) ||
            (o_rsp_valid === 1'b1 && !i_rsp_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        // Shadow state matches the block after reset
        for (int k = 0; k < WIN; k++) window_samples[k] = '0;
        window_slot = 0;
        window_fill = 0;
        approvals   = '0;
        denials     = '0;
        tier_limits.four  = rtwmm_pkg::RST_TIER_FOUR;
        tier_limits.three = rtwmm_pkg::RST_TIER_THREE;
        tier_limits.two   = rtwmm_pkg::RST_TIER_TWO;
        tier_limits.one   = rtwmm_pkg::RST_TIER_ONE;

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_events();
        test_threshold_settings();
        test_random_traffic();

        quiesce();
        if (awaited_reports.size() != 0) begin
            $error("%0d reports never arrived", awaited_reports.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
